// ===== design/assert_macros.svh =====
// Assertion macros used by the port checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// check prop at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// ===== design/agrr_pkg.sv =====
// Package of the 5x7 glyph rasterizer: font tables, character codes, shared types.
// Depends on nothing; used by the interfaces and all modules of the block.
`default_nettype none

package agrr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CODE_W = 8;
	localparam int SCALE_W = 4;
	localparam int COLOR_W = 16;

	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_DOTS = GLYPH_ROWS * GLYPH_COLS;
	localparam int DOT_IDX_W = $clog2(GLYPH_DOTS);
	localparam int POS_W = 3;

	localparam logic [CODE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CODE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CODE_W-1:0] CH_MINUS   = 8'h2d;
	localparam logic [CODE_W-1:0] CH_DOT     = 8'h2e;
	localparam logic [CODE_W-1:0] CH_SLASH   = 8'h2f;
	localparam logic [CODE_W-1:0] CH_0       = 8'h30;
	localparam logic [CODE_W-1:0] CH_9       = 8'h39;
	localparam logic [CODE_W-1:0] CH_COLON   = 8'h3a;
	localparam logic [CODE_W-1:0] CH_A       = 8'h41;
	localparam logic [CODE_W-1:0] CH_Z       = 8'h5a;
	localparam logic [CODE_W-1:0] CH_UNDER   = 8'h5f;
	localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [CODE_W-1:0] CASE_FOLD  = 8'h20;

	localparam logic [4:0] DIGIT_FONT [10][GLYPH_ROWS] = '{
		'{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e},
		'{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
		'{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
		'{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e},
		'{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
		'{5'h1f, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h11, 5'h0e},
		'{5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
		'{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
		'{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h0c}
	};

	localparam logic [4:0] LETTER_FONT [26][GLYPH_ROWS] = '{
		'{5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
		'{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e},
		'{5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f},
		'{5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e},
		'{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f},
		'{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10},
		'{5'h0f, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0f},
		'{5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
		'{5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
		'{5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0e},
		'{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
		'{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f},
		'{5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
		'{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
		'{5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
		'{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10},
		'{5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d},
		'{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11},
		'{5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e},
		'{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a},
		'{5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11},
		'{5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f}
	};

	localparam logic [4:0] MINUS_FONT   [GLYPH_ROWS] = '{5'h00, 5'h00, 5'h00, 5'h1f, 5'h00,
		5'h00, 5'h00};
	localparam logic [4:0] UNDER_FONT   [GLYPH_ROWS] = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
		5'h00, 5'h1f};
	localparam logic [4:0] DOT_FONT     [GLYPH_ROWS] = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
		5'h00, 5'h04};
	localparam logic [4:0] PERCENT_FONT [GLYPH_ROWS] = '{5'h19, 5'h1a, 5'h02, 5'h04, 5'h08,
		5'h0b, 5'h13};
	localparam logic [4:0] COLON_FONT   [GLYPH_ROWS] = '{5'h00, 5'h00, 5'h04, 5'h00, 5'h04,
		5'h00, 5'h00};
	localparam logic [4:0] SLASH_FONT   [GLYPH_ROWS] = '{5'h01, 5'h01, 5'h10, 5'h08, 5'h04,
		5'h02, 5'h01};
	localparam logic [4:0] BLANK_FONT   [GLYPH_ROWS] = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
		5'h00, 5'h00};
	localparam logic [4:0] UNKNOWN_FONT [GLYPH_ROWS] = '{5'h1f, 5'h00, 5'h00, 5'h04, 5'h00,
		5'h00, 5'h1f};

	typedef logic [GLYPH_DOTS-1:0] dot_map_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} dot_pos_t;

	// bit row*GLYPH_COLS+col is lit when the dot at (row, col) is lit
	function automatic dot_map_t glyph_map(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] c;
		logic [4:0] rows [GLYPH_ROWS];
		dot_map_t map;
		c = code;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			c = c - CASE_FOLD;
		for (int r = 0; r < GLYPH_ROWS; r++)
			rows[r] = UNKNOWN_FONT[r];
		priority if (c >= CH_0 && c <= CH_9) begin
			for (int r = 0; r < GLYPH_ROWS; r++)
				rows[r] = DIGIT_FONT[4'(c - CH_0)][r];
		end else if (c >= CH_A && c <= CH_Z) begin
			for (int r = 0; r < GLYPH_ROWS; r++)
				rows[r] = LETTER_FONT[5'(c - CH_A)][r];
		end else begin
			unique case (c)
				CH_SPACE:   for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = BLANK_FONT[r];
				CH_MINUS:   for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = MINUS_FONT[r];
				CH_UNDER:   for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = UNDER_FONT[r];
				CH_DOT:     for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = DOT_FONT[r];
				CH_PERCENT: for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = PERCENT_FONT[r];
				CH_COLON:   for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = COLON_FONT[r];
				CH_SLASH:   for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = SLASH_FONT[r];
				default:    for (int r = 0; r < GLYPH_ROWS; r++) rows[r] = UNKNOWN_FONT[r];
			endcase
		end
		for (int r = 0; r < GLYPH_ROWS; r++)
			for (int k = 0; k < GLYPH_COLS; k++)
				map[r*GLYPH_COLS + k] = rows[r][GLYPH_COLS-1-k];
		return map;
	endfunction

	function automatic dot_pos_t dot_pos(input logic [DOT_IDX_W-1:0] idx);
		dot_pos_t p;
		p.row = '0;
		for (int r = 1; r < GLYPH_ROWS; r++)
			if (idx >= DOT_IDX_W'(r * GLYPH_COLS))
				p.row = POS_W'(r);
		p.col = POS_W'(idx - DOT_IDX_W'(DOT_IDX_W'(p.row) * DOT_IDX_W'(GLYPH_COLS)));
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== design/agrr_stream_if.sv =====
// Request channels of the glyph rasterizer: character requests in, rectangle requests out.
// Depends on agrr_pkg for field widths.
`default_nettype none

interface agrr_char_if #(
	parameter int COORD_BITS = agrr_pkg::COORD_BITS_DEF
);
	import agrr_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [CODE_W-1:0]            char_code;
	logic signed [COORD_BITS-1:0] origin_x;
	logic signed [COORD_BITS-1:0] origin_y;
	logic [SCALE_W-1:0]           scale_x;
	logic [SCALE_W-1:0]           scale_y;
	logic [COLOR_W-1:0]           ink_color;

	modport source (output valid, char_code, origin_x, origin_y, scale_x, scale_y, ink_color,
		input ready);
	modport sink (input valid, char_code, origin_x, origin_y, scale_x, scale_y, ink_color,
		output ready);
endinterface

interface agrr_rect_if #(
	parameter int COORD_BITS = agrr_pkg::COORD_BITS_DEF
);
	import agrr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [COORD_BITS:0] rect_x;
	logic signed [COORD_BITS:0] rect_y;
	logic [SCALE_W-1:0]         rect_w;
	logic [SCALE_W-1:0]         rect_h;
	logic [COLOR_W-1:0]         rect_color;
	logic                       last_rect;

	modport source (output valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
		input ready);
	modport sink (input valid, rect_x, rect_y, rect_w, rect_h, rect_color, last_rect,
		output ready);
endinterface

`default_nettype wire

// ===== design/agrr_front.sv =====
// Front end: accepts character requests, looks up the glyph dot map, drops blank glyphs.
// Depends on agrr_pkg and agrr_char_if; pushes packed jobs into agrr_queue.
`default_nettype none

module agrr_front #(
	parameter int COORD_BITS = agrr_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W = agrr_pkg::GLYPH_DOTS + 2*COORD_BITS + 2*agrr_pkg::SCALE_W
		+ agrr_pkg::COLOR_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	agrr_char_if.sink                chars,
	input  wire agrr_pkg::q_stat_t   q_stat,
	output logic                     push,
	output logic [ENTRY_W-1:0]       push_data
);
	import agrr_pkg::*;

	logic                         valid_s1;
	logic [CODE_W-1:0]            code_s1;
	logic signed [COORD_BITS-1:0] ox_s1;
	logic signed [COORD_BITS-1:0] oy_s1;
	logic [SCALE_W-1:0]           sx_s1;
	logic [SCALE_W-1:0]           sy_s1;
	logic [COLOR_W-1:0]           color_s1;
	dot_map_t                     map_s1;
	logic                         blank_s1;
	logic                         leave_s1;
	logic                         take;

	assign map_s1    = glyph_map(code_s1);
	assign blank_s1  = (map_s1 == '0);
	assign leave_s1  = valid_s1 && (blank_s1 || !q_stat.full);
	assign chars.ready = !valid_s1 || leave_s1;
	assign take      = chars.valid && chars.ready;
	assign push      = valid_s1 && !blank_s1 && !q_stat.full;
	assign push_data = {map_s1, ox_s1, oy_s1, sx_s1, sy_s1, color_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (leave_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_s1  <= chars.char_code;
			ox_s1    <= chars.origin_x;
			oy_s1    <= chars.origin_y;
			sx_s1    <= chars.scale_x;
			sy_s1    <= chars.scale_y;
			color_s1 <= chars.ink_color;
		end
	end

endmodule

`default_nettype wire

// ===== design/agrr_queue.sv =====
// Short job queue between the front end and the dot walker.
// Depends on agrr_pkg for the status struct.
`default_nettype none

module agrr_queue #(
	parameter int DEPTH = agrr_pkg::QUEUE_DEPTH_DEF,
	parameter int WIDTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [WIDTH-1:0]   push_data,
	input  wire logic               pop,
	output logic [WIDTH-1:0]        pop_data,
	output agrr_pkg::q_stat_t       q_stat
);
	import agrr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;
	assign pop_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== design/agrr_back.sv =====
// Back end: walks a glyph's lit dots; one rectangle request per cycle unless stalled.
// Depends on agrr_pkg and agrr_rect_if; pops packed jobs from agrr_queue.
`default_nettype none

module agrr_back #(
	parameter int COORD_BITS = agrr_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W = agrr_pkg::GLYPH_DOTS + 2*COORD_BITS + 2*agrr_pkg::SCALE_W
		+ agrr_pkg::COLOR_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire agrr_pkg::q_stat_t   q_stat,
	input  wire logic [ENTRY_W-1:0]  pop_data,
	output logic                     pop,
	agrr_rect_if.source              rects
);
	import agrr_pkg::*;

	localparam int CW = COORD_BITS + 1;
	localparam int PW = 7;

	dot_map_t                     cur_q;
	logic                         busy_q;
	logic [COORD_BITS-1:0]        ox_q;
	logic [COORD_BITS-1:0]        oy_q;
	logic [SCALE_W-1:0]           sx_q;
	logic [SCALE_W-1:0]           sy_q;
	logic [COLOR_W-1:0]           color_q;

	logic                         out_valid_q;
	logic [CW-1:0]                rx_q;
	logic [CW-1:0]                ry_q;
	logic [SCALE_W-1:0]           rw_q;
	logic [SCALE_W-1:0]           rh_q;
	logic [COLOR_W-1:0]           rcolor_q;
	logic                         rlast_q;

	dot_map_t                     in_map;
	logic [COORD_BITS-1:0]        in_ox;
	logic [COORD_BITS-1:0]        in_oy;
	logic [SCALE_W-1:0]           in_sx;
	logic [SCALE_W-1:0]           in_sy;
	logic [COLOR_W-1:0]           in_color;

	logic                         adv;
	logic                         emit;
	logic                         last;
	dot_map_t                     rest;
	logic [DOT_IDX_W-1:0]         idx;
	dot_pos_t                     pos;
	logic [PW-1:0]                offs_x;
	logic [PW-1:0]                offs_y;
	logic [CW-1:0]                nx;
	logic [CW-1:0]                ny;

	assign {in_map, in_ox, in_oy, in_sx, in_sy, in_color} = pop_data;

	always_comb begin
		idx = '0;
		for (int i = GLYPH_DOTS - 1; i >= 0; i--)
			if (cur_q[i])
				idx = DOT_IDX_W'(i);
	end

	assign pos    = dot_pos(idx);
	assign offs_x = PW'(pos.col) * PW'(sx_q);
	assign offs_y = PW'(pos.row) * PW'(sy_q);
	assign nx     = {ox_q[COORD_BITS-1], ox_q} + CW'(offs_x);
	assign ny     = {oy_q[COORD_BITS-1], oy_q} + CW'(offs_y);
	assign rest   = cur_q & (cur_q - 1'b1);
	assign last   = (rest == '0);

	assign adv  = !out_valid_q || rects.ready;
	assign emit = busy_q && adv;
	assign pop  = !q_stat.empty && (!busy_q || (emit && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				busy_q <= 1'b1;
			else if (emit && last)
				busy_q <= 1'b0;
			if (adv)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q   <= in_map;
			ox_q    <= in_ox;
			oy_q    <= in_oy;
			sx_q    <= in_sx;
			sy_q    <= in_sy;
			color_q <= in_color;
		end else if (emit) begin
			cur_q <= rest;
		end
		if (emit) begin
			rx_q     <= nx;
			ry_q     <= ny;
			rw_q     <= sx_q;
			rh_q     <= sy_q;
			rcolor_q <= color_q;
			rlast_q  <= last;
		end
	end

	assign rects.valid      = out_valid_q;
	assign rects.rect_x     = rx_q;
	assign rects.rect_y     = ry_q;
	assign rects.rect_w     = rw_q;
	assign rects.rect_h     = rh_q;
	assign rects.rect_color = rcolor_q;
	assign rects.last_rect  = rlast_q;

endmodule

`default_nettype wire

// ===== design/ascii_glyph_rect_rasterizer_top.sv =====
// Top level of the 5x7 glyph rasterizer: front end, job queue and dot walker.
// Depends on agrr_pkg, agrr_stream_if, agrr_front, agrr_queue and agrr_back.
//
// Usage:
//   chars carries one character request: code, cell origin, dot scale and color.
//   rects carries one filled rectangle request per lit font dot, in row-major
//   order; last_rect marks the final rectangle of a character.
//   A character is accepted when chars.valid and chars.ready are high at a clock edge.
//   A character passes the front stage register and the queue to the dot walker,
//   which registers its rectangles. Throughput: one rectangle per cycle while
//   rects.ready is high; a character with n lit dots (at most 35) holds the walker
//   for n rectangles. A blank glyph leaves the front stage unqueued, with no
//   rectangle. The walker pops a queued job as it emits the prior job's last dot.
//   The queue holds QUEUE_DEPTH glyph jobs, so the front end keeps accepting while
//   the dot walker is busy; chars.ready drops once the queue and front stage are full.
//   When rects.ready is low with a valid rectangle, the rectangle register holds and the walker stalls.
//   Reset (arst_n low) empties the front stage, the queue and the output register.
`default_nettype none

module ascii_glyph_rect_rasterizer_top #(
	parameter int COORD_BITS = agrr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = agrr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	agrr_char_if.sink    chars,
	agrr_rect_if.source  rects
);
	import agrr_pkg::*;

	localparam int ENTRY_W = GLYPH_DOTS + 2*COORD_BITS + 2*SCALE_W + COLOR_W;

	q_stat_t              q_stat;
	logic                 push;
	logic [ENTRY_W-1:0]   push_data;
	logic                 pop;
	logic [ENTRY_W-1:0]   pop_data;

	agrr_front #(
		.COORD_BITS(COORD_BITS),
		.ENTRY_W(ENTRY_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.q_stat(q_stat),
		.push(push),
		.push_data(push_data)
	);

	agrr_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.q_stat(q_stat)
	);

	agrr_back #(
		.COORD_BITS(COORD_BITS),
		.ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.pop_data(pop_data),
		.pop(pop),
		.rects(rects)
	);

endmodule

`default_nettype wire

// ===== design/agrr_port_checker.sv =====
// Port checker of the glyph rasterizer, bound to the top level.
// Depends on agrr_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module agrr_port_checker #(
	parameter int COORD_BITS = agrr_pkg::COORD_BITS_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         rect_valid,
	input wire logic                         rect_ready,
	input wire logic [COORD_BITS:0]          rect_x,
	input wire logic [COORD_BITS:0]          rect_y,
	input wire logic [agrr_pkg::SCALE_W-1:0] rect_w,
	input wire logic [agrr_pkg::SCALE_W-1:0] rect_h,
	input wire logic [agrr_pkg::COLOR_W-1:0] rect_color,
	input wire logic                         last_rect
);
	import agrr_pkg::*;

	logic                                       stalled;
	logic                                       taken_mid;
	logic [2*(COORD_BITS+1)+2*SCALE_W+COLOR_W:0] req_bits;
	logic [2*SCALE_W+COLOR_W-1:0]               fmt_bits;

	assign stalled   = rect_valid && !rect_ready;
	assign taken_mid = rect_valid && rect_ready && !last_rect;
	assign req_bits  = {rect_x, rect_y, rect_w, rect_h, rect_color, last_rect};
	assign fmt_bits  = {rect_w, rect_h, rect_color};

	// hold a stalled rectangle request unchanged
	`ASSERT_CLK(a_stall_hold, clk, arst_n, stalled |=> rect_valid && $stable(req_bits))

	// follow a taken non-final rectangle at once with one of the same character
	`ASSERT_CLK(a_glyph_burst, clk, arst_n, taken_mid |=> rect_valid && $stable(fmt_bits))

	// drop every request while reset is held
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !rect_valid)

endmodule

bind ascii_glyph_rect_rasterizer_top agrr_port_checker #(
	.COORD_BITS(COORD_BITS)
) u_port_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rect_valid(rects.valid),
	.rect_ready(rects.ready),
	.rect_x(rects.rect_x),
	.rect_y(rects.rect_y),
	.rect_w(rects.rect_w),
	.rect_h(rects.rect_h),
	.rect_color(rects.rect_color),
	.last_rect(rects.last_rect)
);

`default_nettype wire

// ===== tb/tb_ascii_glyph_rect_rasterizer_top.sv =====
// Testbench of the 5x7 glyph rasterizer: drives character requests, predicts every rectangle.
// Depends on agrr_pkg, agrr_stream_if and ascii_glyph_rect_rasterizer_top.
// Directed corner characters come first, then random text under random stalls and a long hold.
`default_nettype none

module tb_ascii_glyph_rect_rasterizer_top;
	import agrr_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int RANDOM_CHARS = 236;
	localparam int HOLD_AT = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	localparam logic [CODE_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CODE_W-1:0] CH_AT        = 8'h40;
	localparam logic [CODE_W-1:0] CH_LBRACKET  = 8'h5b;
	localparam logic [CODE_W-1:0] CH_BACKTICK  = 8'h60;
	localparam logic [CODE_W-1:0] CH_LBRACE    = 8'h7b;
	localparam logic [CODE_W-1:0] CH_DEL       = 8'h7f;
	localparam logic [CODE_W-1:0] CH_HIGH      = 8'h80;
	localparam logic [CODE_W-1:0] CH_TOP       = 8'hff;

	typedef logic [0:GLYPH_ROWS-1][4:0] glyph_t;

	localparam glyph_t DIGIT_GLYPH [10] = '{
		{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e},
		{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
		{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
		{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e},
		{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
		{5'h1f, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h11, 5'h0e},
		{5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
		{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
		{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h0c}
	};

	localparam glyph_t LETTER_GLYPH [26] = '{
		{5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
		{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e},
		{5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f},
		{5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e},
		{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f},
		{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10},
		{5'h0f, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0f},
		{5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
		{5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
		{5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0e},
		{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
		{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f},
		{5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
		{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
		{5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
		{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10},
		{5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d},
		{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11},
		{5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e},
		{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
		{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
		{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04},
		{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a},
		{5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11},
		{5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04},
		{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f}
	};

	localparam glyph_t GLYPH_MINUS   = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
	localparam glyph_t GLYPH_UNDER   = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1f};
	localparam glyph_t GLYPH_DOT     = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
	localparam glyph_t GLYPH_PERCENT = {5'h19, 5'h1a, 5'h02, 5'h04, 5'h08, 5'h0b, 5'h13};
	localparam glyph_t GLYPH_COLON   = {5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00};
	localparam glyph_t GLYPH_SLASH   = {5'h01, 5'h01, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01};
	localparam glyph_t GLYPH_BLANK   = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
	localparam glyph_t GLYPH_UNKNOWN = {5'h1f, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00, 5'h1f};

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [CB-1:0]      origin_x;
		logic [CB-1:0]      origin_y;
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;
		logic [COLOR_W-1:0] ink_color;
	} char_req_t;

	typedef struct {
		char_req_t req;
		int        gap;
		bit        wait_drain;
	} char_item_t;

	typedef struct packed {
		logic [CB:0]        x;
		logic [CB:0]        y;
		logic [SCALE_W-1:0] w;
		logic [SCALE_W-1:0] h;
		logic [COLOR_W-1:0] color;
		logic               last_rect;
	} rect_t;

	logic clk;
	logic arst_n;

	agrr_char_if #(.COORD_BITS(CB)) chars_if ();
	agrr_rect_if #(.COORD_BITS(CB)) rects_if ();

	ascii_glyph_rect_rasterizer_top #(.COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.rects  (rects_if)
	);

	char_item_t char_backlog [$];
	rect_t      pending_rects [$];
	int         mismatches = 0;
	int         gap_left;
	int         stall_left;
	int         rects_taken;
	int         chars_taken;
	int         hold_left;
	bit         hold_armed;
	bit         rects_drained;

	function automatic glyph_t glyph_of(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] c;
		c = code;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			c = c - CASE_FOLD;
		if (c >= CH_0 && c <= CH_9)
			return DIGIT_GLYPH[c - CH_0];
		if (c >= CH_A && c <= CH_Z)
			return LETTER_GLYPH[c - CH_A];
		case (c)
			CH_SPACE:   return GLYPH_BLANK;
			CH_MINUS:   return GLYPH_MINUS;
			CH_UNDER:   return GLYPH_UNDER;
			CH_DOT:     return GLYPH_DOT;
			CH_PERCENT: return GLYPH_PERCENT;
			CH_COLON:   return GLYPH_COLON;
			CH_SLASH:   return GLYPH_SLASH;
			default:    return GLYPH_UNKNOWN;
		endcase
	endfunction

	task automatic rasterize_glyph(input char_req_t req);
		glyph_t g;
		rect_t r;
		int lit;
		int k;
		int ox;
		int oy;
		int rx;
		int ry;
		g = glyph_of(req.code);
		ox = $signed(req.origin_x);
		oy = $signed(req.origin_y);
		lit = 0;
		for (int row = 0; row < GLYPH_ROWS; row++)
			for (int col = 0; col < GLYPH_COLS; col++)
				if (g[row][4-col])
					lit++;
		k = 0;
		for (int row = 0; row < GLYPH_ROWS; row++)
			for (int col = 0; col < GLYPH_COLS; col++)
				if (g[row][4-col]) begin
					k++;
					rx = ox + col * int'(req.scale_x);
					ry = oy + row * int'(req.scale_y);
					r.x = rx[CB:0];
					r.y = ry[CB:0];
					r.w = req.scale_x;
					r.h = req.scale_y;
					r.color = req.ink_color;
					r.last_rect = (k == lit);
					pending_rects.push_back(r);
				end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at rect %0d, %s: got %0h, expected %0h", rects_taken, what, got,
			want);
		mismatches++;
	endtask

	task automatic add_char(input logic [CODE_W-1:0] code, input int ox, input int oy,
		input int sx, input int sy, input int color, input bit wait_drain);
		char_item_t it;
		int idx;
		idx = char_backlog.size();
		it.req.code = code;
		it.req.origin_x = ox[CB-1:0];
		it.req.origin_y = oy[CB-1:0];
		it.req.scale_x = sx[SCALE_W-1:0];
		it.req.scale_y = sy[SCALE_W-1:0];
		it.req.ink_color = color[COLOR_W-1:0];
		it.wait_drain = wait_drain;
		if (idx % 60 < 12 || (idx >= HOLD_AT - 10 && idx < HOLD_AT + 30))
			it.gap = 0;
		else
			it.gap = $urandom_range(0, 15);
		char_backlog.push_back(it);
	endtask

	function automatic logic [CODE_W-1:0] random_code();
		case ($urandom_range(0, 9))
			0, 1, 2: return CH_A + CODE_W'($urandom_range(0, 25));
			3:       return CH_LOWER_A + CODE_W'($urandom_range(0, 25));
			4, 5:    return CH_0 + CODE_W'($urandom_range(0, 9));
			6: begin
				case ($urandom_range(0, 6))
					0:       return CH_SPACE;
					1:       return CH_MINUS;
					2:       return CH_UNDER;
					3:       return CH_DOT;
					4:       return CH_PERCENT;
					5:       return CH_COLON;
					default: return CH_SLASH;
				endcase
			end
			default: return CODE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int random_origin();
		case ($urandom_range(0, 7))
			0:       return 2047;
			1:       return -2048;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic int random_scale();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 15);
		return $urandom_range(1, 8);
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		char_item_t it;
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.char_code <= '0;
			chars_if.origin_x <= '0;
			chars_if.origin_y <= '0;
			chars_if.scale_x <= '0;
			chars_if.scale_y <= '0;
			chars_if.ink_color <= '0;
			gap_left <= 0;
		end else if (!chars_if.valid || chars_if.ready) begin
			if (gap_left > 0) begin
				chars_if.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (char_backlog.size() > 0 &&
				(!char_backlog[0].wait_drain || (rects_drained && !chars_if.valid))) begin
				it = char_backlog.pop_front();
				chars_if.valid <= 1'b1;
				chars_if.char_code <= it.req.code;
				chars_if.origin_x <= it.req.origin_x;
				chars_if.origin_y <= it.req.origin_y;
				chars_if.scale_x <= it.req.scale_x;
				chars_if.scale_y <= it.req.scale_y;
				chars_if.ink_color <= it.req.ink_color;
				gap_left <= it.gap;
			end else begin
				chars_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		char_req_t req;
		rect_t want;
		int wait_n;
		if (!arst_n) begin
			rects_if.ready <= 1'b0;
			stall_left <= 0;
			rects_drained <= 1'b1;
			chars_taken <= 0;
			rects_taken = 0;
		end else begin
			if (chars_if.valid && chars_if.ready) begin
				req.code = chars_if.char_code;
				req.origin_x = chars_if.origin_x;
				req.origin_y = chars_if.origin_y;
				req.scale_x = chars_if.scale_x;
				req.scale_y = chars_if.scale_y;
				req.ink_color = chars_if.ink_color;
				rasterize_glyph(req);
				chars_taken <= chars_taken + 1;
			end
			wait_n = stall_left;
			if (rects_if.valid && rects_if.ready) begin
				if (pending_rects.size() == 0) begin
					report_mismatch("rect with no character pending", 0, 0);
				end else begin
					want = pending_rects.pop_front();
					if (rects_if.rect_x !== want.x)
						report_mismatch("rect_x", rects_if.rect_x, want.x);
					if (rects_if.rect_y !== want.y)
						report_mismatch("rect_y", rects_if.rect_y, want.y);
					if (rects_if.rect_w !== want.w)
						report_mismatch("rect_w", rects_if.rect_w, want.w);
					if (rects_if.rect_h !== want.h)
						report_mismatch("rect_h", rects_if.rect_h, want.h);
					if (rects_if.rect_color !== want.color)
						report_mismatch("rect_color", rects_if.rect_color, want.color);
					if (rects_if.last_rect !== want.last_rect)
						report_mismatch("last_rect", rects_if.last_rect, want.last_rect);
				end
				rects_taken++;
				wait_n = ((rects_taken / 64) % 4 == 1) ? 0 : $urandom_range(0, 15);
			end
			rects_drained <= (pending_rects.size() == 0);
			if (wait_n > 0) begin
				stall_left <= wait_n - 1;
				rects_if.ready <= 1'b0;
			end else begin
				stall_left <= 0;
				rects_if.ready <= (hold_left == 0);
			end
		end
	end

	// hold off the rectangle side once so the queue fills and chars.ready drops
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_armed <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && chars_taken == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_armed <= 1'b0;
		end
	end

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_code = '0;
		chars_if.origin_x = '0;
		chars_if.origin_y = '0;
		chars_if.scale_x = '0;
		chars_if.scale_y = '0;
		chars_if.ink_color = '0;
		rects_if.ready = 1'b0;

		add_char(CH_A, 0, 0, 1, 1, 0, 1'b0);
		add_char(CH_LOWER_Z, -2048, -2048, 8, 8, 16'hffff, 1'b0);
		add_char(CH_0, 2047, 2047, 8, 8, 16'h8000, 1'b0);
		add_char(CH_9, -1, 1, 1, 8, 16'h5555, 1'b0);
		add_char(CH_SPACE, 100, 100, 3, 3, 16'h1234, 1'b0);
		add_char(CH_MINUS, -7, 9, 2, 3, 16'haaaa, 1'b0);
		add_char(CH_UNDER, 300, -300, 4, 1, 16'h0f0f, 1'b0);
		add_char(CH_DOT, 0, 0, 8, 8, 16'hf0f0, 1'b0);
		add_char(CH_PERCENT, 1000, -1000, 5, 6, 16'h00ff, 1'b0);
		add_char(CH_COLON, -1, -1, 7, 7, 16'hff00, 1'b0);
		add_char(CH_SLASH, 12, 34, 1, 2, 16'h2468, 1'b0);
		add_char(CH_NUL, 2047, -2048, 8, 1, 16'h1357, 1'b0);
		add_char(CH_DEL, -2048, 2047, 1, 8, 16'h7fff, 1'b0);
		add_char(CH_HIGH, 5, 5, 3, 3, 16'h0001, 1'b0);
		add_char(CH_TOP, -5, -5, 2, 2, 16'hfffe, 1'b0);
		add_char(CH_AT, 64, 64, 1, 1, 16'h4000, 1'b0);
		add_char(CH_LBRACKET, 64, 64, 1, 1, 16'h0002, 1'b0);
		add_char(CH_BACKTICK, 64, 64, 1, 1, 16'h0004, 1'b0);
		add_char(CH_LBRACE, 64, 64, 1, 1, 16'h0008, 1'b0);
		add_char(CH_LOWER_A, 2047, 2047, 0, 15, 16'hbeef, 1'b0);
		add_char(CH_0 + 8'd8, 2047, -2048, 15, 0, 16'hcafe, 1'b0);
		add_char(CH_A + 8'd12, -2048, -2048, 15, 15, 16'h3c3c, 1'b0);
		add_char(CH_SPACE, 0, 0, 15, 15, 16'hc3c3, 1'b0);
		add_char(CH_Z, 1, 2, 3, 4, 16'h5a5a, 1'b1);
		for (int i = 0; i < RANDOM_CHARS; i++)
			add_char(random_code(), random_origin(), random_origin(), random_scale(),
				random_scale(), $urandom_range(0, 65535), (i % 100 == 99));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (char_backlog.size() != 0 || chars_if.valid)
			@(negedge clk);
		while (pending_rects.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_rects.size() != 0)
			report_mismatch("rects never produced", pending_rects.size(), 0);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
